@@ design/apec_pkg.sv @@
// Shared types and constants for the axis projection extent center block.
// Holds the point, center and frame axis formats and the register indexes.
// No dependencies.
`timescale 1ns / 1ps

package apec_pkg;

  localparam int FIELD_WIDTH       = 32;
  localparam int AXIS_WIDTH        = 16;
  localparam int CFG_INDEX_WIDTH   = 3;
  localparam int WRAP_WIDTH        = 64;
  localparam int QUEUE_DEPTH       = 4;
  localparam int QUEUE_PTR_WIDTH   = 2;
  localparam int QUEUE_COUNT_WIDTH = 3;

  // Q1.14 unit value used as the reset of the two diagonal axis components.
  localparam logic signed [AXIS_WIDTH-1:0] AXIS_RESET_ONE  = 16'sd16384;
  localparam logic signed [AXIS_WIDTH-1:0] AXIS_RESET_ZERO = 16'sd0;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    CFG_FIRST_X  = 3'd0,
    CFG_FIRST_Y  = 3'd1,
    CFG_FIRST_Z  = 3'd2,
    CFG_SECOND_X = 3'd3,
    CFG_SECOND_Y = 3'd4,
    CFG_SECOND_Z = 3'd5
  } cfg_index_t;

  typedef struct packed {
    logic signed [FIELD_WIDTH-1:0] point_x;
    logic signed [FIELD_WIDTH-1:0] point_y;
    logic signed [FIELD_WIDTH-1:0] point_z;
    logic                          last_point;
  } point_t;

  typedef struct packed {
    logic signed [FIELD_WIDTH-1:0] center_x;
    logic signed [FIELD_WIDTH-1:0] center_y;
    logic signed [FIELD_WIDTH-1:0] center_z;
  } center_t;

  typedef struct packed {
    logic signed [AXIS_WIDTH-1:0] first_x;
    logic signed [AXIS_WIDTH-1:0] first_y;
    logic signed [AXIS_WIDTH-1:0] first_z;
    logic signed [AXIS_WIDTH-1:0] second_x;
    logic signed [AXIS_WIDTH-1:0] second_y;
    logic signed [AXIS_WIDTH-1:0] second_z;
  } axes_t;

endpackage

@@ design/apec_front.sv @@
// Front end: accepts points, projects them on both frame axes in two stages
// and pushes point plus projections into the queue. Uses apec_pkg.
`timescale 1ns / 1ps

module apec_front #(
  parameter int COORD_WIDTH    = 32,
  parameter int AXIS_FRAC_BITS = 14
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       point_valid,
  output logic                                       point_ready,
  input  apec_pkg::point_t                           point,
  input  apec_pkg::axes_t                            axes,
  input  logic [apec_pkg::QUEUE_COUNT_WIDTH-1:0]     queue_count,
  output logic                                       push,
  output logic [3*COORD_WIDTH+2*(COORD_WIDTH+2):0]   push_data
);
  import apec_pkg::*;

  localparam int PROJ_W  = COORD_WIDTH + 2;
  localparam int PROD_W  = COORD_WIDTH + AXIS_WIDTH;
  localparam int PSUM_W  = (COORD_WIDTH + 17 < WRAP_WIDTH) ? COORD_WIDTH + 17 : WRAP_WIDTH;

  logic signed [COORD_WIDTH-1:0] coord [3];
  logic signed [AXIS_WIDTH-1:0]  axis1 [3];
  logic signed [AXIS_WIDTH-1:0]  axis2 [3];

  logic                          a_valid;
  logic signed [COORD_WIDTH-1:0] a_coord [3];
  logic                          a_last;
  logic signed [PROD_W-1:0]      a_prod1 [3];
  logic signed [PROD_W-1:0]      a_prod2 [3];

  logic signed [PSUM_W-1:0]      sum1, sum2, sh1, sh2;
  logic [PSUM_W-PROJ_W:0]        top1, top2;
  logic signed [PROJ_W-1:0]      proj1, proj2;

  logic                          b_valid;
  logic [3*COORD_WIDTH+2*PROJ_W:0] b_entry;

  logic [QUEUE_COUNT_WIDTH-1:0]  occupancy;
  logic                          take;

  // Coordinates come from the low bits of each field; a wider coordinate
  // zero-fills above the field.
  assign coord[0] = COORD_WIDTH'($unsigned(point.point_x));
  assign coord[1] = COORD_WIDTH'($unsigned(point.point_y));
  assign coord[2] = COORD_WIDTH'($unsigned(point.point_z));

  assign axis1[0] = axes.first_x;
  assign axis1[1] = axes.first_y;
  assign axis1[2] = axes.first_z;
  assign axis2[0] = axes.second_x;
  assign axis2[1] = axes.second_y;
  assign axis2[2] = axes.second_z;

  // Everything in flight counts against the queue, so a pushed item always fits.
  assign occupancy   = queue_count + QUEUE_COUNT_WIDTH'(a_valid)
                     + QUEUE_COUNT_WIDTH'(b_valid);
  assign point_ready = occupancy < QUEUE_COUNT_WIDTH'(QUEUE_DEPTH);
  assign take        = point_valid && point_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= take;
    end
    a_last <= point.last_point;
    for (int j = 0; j < 3; j++) begin
      a_coord[j] <= coord[j];
      a_prod1[j] <= coord[j] * axis1[j];
      a_prod2[j] <= coord[j] * axis2[j];
    end
  end

  always_comb begin
    sum1 = PSUM_W'(a_prod1[0]) + PSUM_W'(a_prod1[1]) + PSUM_W'(a_prod1[2]);
    sum2 = PSUM_W'(a_prod2[0]) + PSUM_W'(a_prod2[1]) + PSUM_W'(a_prod2[2]);
    sh1  = sum1 >>> AXIS_FRAC_BITS;
    sh2  = sum2 >>> AXIS_FRAC_BITS;
    top1 = sh1[PSUM_W-1:PROJ_W-1];
    top2 = sh2[PSUM_W-1:PROJ_W-1];
    // The value fits when the bits above the result are all sign copies.
    if ((&top1) || !(|top1)) begin
      proj1 = sh1[PROJ_W-1:0];
    end else begin
      proj1 = {sh1[PSUM_W-1], {(PROJ_W-1){~sh1[PSUM_W-1]}}};
    end
    if ((&top2) || !(|top2)) begin
      proj2 = sh2[PROJ_W-1:0];
    end else begin
      proj2 = {sh2[PSUM_W-1], {(PROJ_W-1){~sh2[PSUM_W-1]}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= a_valid;
    end
    b_entry <= {a_last, a_coord[2], a_coord[1], a_coord[0], proj2, proj1};
  end

  assign push      = b_valid;
  assign push_data = b_entry;

endmodule

@@ design/apec_queue.sv @@
// Short first-in first-out queue between the front and back ends.
// Holds projected points; depth comes from apec_pkg.
`timescale 1ns / 1ps

module apec_queue #(
  parameter int WIDTH = 163
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   push,
  input  logic [WIDTH-1:0]                       push_data,
  input  logic                                   pop,
  output logic [WIDTH-1:0]                       pop_data,
  output logic [apec_pkg::QUEUE_COUNT_WIDTH-1:0] count
);
  import apec_pkg::*;

  logic [WIDTH-1:0]           slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_WIDTH-1:0] wr_ptr;
  logic [QUEUE_PTR_WIDTH-1:0] rd_ptr;

  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

@@ design/apec_back.sv @@
// Back end: drains the queue, keeps the running extents and kept coordinates,
// and on a cluster's last point works out the saturated center. Uses apec_pkg.
`timescale 1ns / 1ps

module apec_back #(
  parameter int COORD_WIDTH    = 32,
  parameter int AXIS_FRAC_BITS = 14
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  apec_pkg::axes_t                            axes,
  input  logic [apec_pkg::QUEUE_COUNT_WIDTH-1:0]     queue_count,
  input  logic [3*COORD_WIDTH+2*(COORD_WIDTH+2):0]   pop_data,
  output logic                                       pop,
  output logic                                       center_valid,
  input  logic                                       center_ready,
  output apec_pkg::center_t                          center
);
  import apec_pkg::*;

  localparam int PROJ_W = COORD_WIDTH + 2;
  localparam int MUL_W  = PROJ_W + 1 + AXIS_WIDTH;
  localparam int CSUM_W = (COORD_WIDTH + 21 < WRAP_WIDTH) ? COORD_WIDTH + 21 : WRAP_WIDTH;

  typedef enum logic [3:0] {
    ST_ACC  = 4'b0001,
    ST_HALF = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_SUM  = 4'b1000
  } state_t;

  state_t state;

  logic signed [AXIS_WIDTH-1:0]  axis1 [3];
  logic signed [AXIS_WIDTH-1:0]  axis2 [3];

  logic signed [PROJ_W-1:0]      e_proj1, e_proj2;
  logic signed [COORD_WIDTH-1:0] e_coord [3];
  logic                          e_last;

  logic signed [PROJ_W-1:0]      first_low, first_high, second_low, second_high;
  logic signed [COORD_WIDTH-1:0] kept [3];
  logic                          cluster_open;

  logic signed [PROJ_W:0]        diff1, diff2;
  logic [PROJ_W-1:0]             half1, half2;
  logic signed [MUL_W-1:0]       m1 [3];
  logic signed [MUL_W-1:0]       m2 [3];

  logic signed [CSUM_W-1:0]      csum [3];
  logic signed [CSUM_W-1:0]      cshift [3];
  logic signed [COORD_WIDTH-1:0] csat [3];
  logic                          load;

  assign axis1[0] = axes.first_x;
  assign axis1[1] = axes.first_y;
  assign axis1[2] = axes.first_z;
  assign axis2[0] = axes.second_x;
  assign axis2[1] = axes.second_y;
  assign axis2[2] = axes.second_z;

  assign {e_last, e_coord[2], e_coord[1], e_coord[0], e_proj2, e_proj1} = pop_data;

  assign pop  = (state == ST_ACC) && (queue_count != '0);
  assign load = (state == ST_SUM) && (!center_valid || center_ready);

  // High never falls below low, so the extent is non-negative.
  assign diff1 = {first_high[PROJ_W-1], first_high} - {first_low[PROJ_W-1], first_low};
  assign diff2 = {second_high[PROJ_W-1], second_high}
               - {second_low[PROJ_W-1], second_low};

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      csum[j]   = (CSUM_W'(kept[j]) <<< AXIS_FRAC_BITS) + CSUM_W'(m1[j]) + CSUM_W'(m2[j]);
      cshift[j] = csum[j] >>> AXIS_FRAC_BITS;
      if ((&cshift[j][CSUM_W-1:COORD_WIDTH-1]) || !(|cshift[j][CSUM_W-1:COORD_WIDTH-1])) begin
        csat[j] = cshift[j][COORD_WIDTH-1:0];
      end else begin
        csat[j] = {cshift[j][CSUM_W-1], {(COORD_WIDTH-1){~cshift[j][CSUM_W-1]}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_ACC;
      cluster_open <= 1'b0;
      center_valid <= 1'b0;
    end else begin
      case (state)
        ST_ACC: begin
          if (pop) begin
            cluster_open <= !e_last;
            if (e_last) begin
              state <= ST_HALF;
            end
          end
        end
        ST_HALF: begin
          state <= ST_MUL;
        end
        ST_MUL: begin
          state <= ST_SUM;
        end
        ST_SUM: begin
          if (load) begin
            state <= ST_ACC;
          end
        end
        default: begin
          state <= ST_ACC;
        end
      endcase
      if (load) begin
        center_valid <= 1'b1;
      end else if (center_ready) begin
        center_valid <= 1'b0;
      end
    end

    // Extent tracking; only a strict improvement moves a bound.
    if (pop) begin
      if (!cluster_open) begin
        first_low   <= e_proj1;
        first_high  <= e_proj1;
        second_low  <= e_proj2;
        second_high <= e_proj2;
        for (int j = 0; j < 3; j++) begin
          kept[j] <= e_coord[j];
        end
      end else begin
        if (e_proj1 > first_high) begin
          first_high <= e_proj1;
        end
        if (e_proj1 < first_low) begin
          first_low <= e_proj1;
          kept[0]   <= e_coord[0];
        end
        if (e_proj2 > second_high) begin
          second_high <= e_proj2;
        end
        if (e_proj2 < second_low) begin
          second_low <= e_proj2;
          kept[1]    <= e_coord[1];
        end
      end
    end

    if (state == ST_HALF) begin
      half1 <= diff1[PROJ_W:1];
      half2 <= diff2[PROJ_W:1];
    end

    if (state == ST_MUL) begin
      for (int j = 0; j < 3; j++) begin
        m1[j] <= signed'({1'b0, half1}) * axis1[j];
        m2[j] <= signed'({1'b0, half2}) * axis2[j];
      end
    end

    if (load) begin
      center.center_x <= FIELD_WIDTH'(csat[0]);
      center.center_y <= FIELD_WIDTH'(csat[1]);
      center.center_z <= FIELD_WIDTH'(csat[2]);
    end
  end

endmodule

@@ design/axis_projection_extent_center.sv @@
// Axis projection extent center. Points of a cluster stream in one per clock
// while the front end is ready; each is projected on the two frame axes in a
// two-stage front end and queued for the back end, which updates the extents
// at one point per clock while it accumulates and the queue holds points.
// After the cluster's last point the back end works out half extents,
// products, then sum and saturation before the center is shown; meanwhile
// the front end keeps taking points until the four-entry queue, with points
// still in flight, is full. The axes must be written only while the block
// is idle; writes are always taken.
// Uses apec_pkg, apec_front, apec_queue and apec_back.
`timescale 1ns / 1ps

module axis_projection_extent_center #(
  parameter int COORD_WIDTH    = 32,
  parameter int AXIS_FRAC_BITS = 14
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 point_valid,
  output logic                                 point_ready,
  input  apec_pkg::point_t                     point,
  output logic                                 center_valid,
  input  logic                                 center_ready,
  output apec_pkg::center_t                    center,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [apec_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [apec_pkg::AXIS_WIDTH-1:0]      cfg_data
);
  import apec_pkg::*;

  localparam int ENTRY_W = 3 * COORD_WIDTH + 2 * (COORD_WIDTH + 2) + 1;

  axes_t                         axes;
  logic                          push;
  logic                          pop;
  logic [ENTRY_W-1:0]            push_data;
  logic [ENTRY_W-1:0]            pop_data;
  logic [QUEUE_COUNT_WIDTH-1:0]  queue_count;

  assign cfg_ready = 1'b1;

  // Indexes past the last register are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      axes.first_x  <= AXIS_RESET_ONE;
      axes.first_y  <= AXIS_RESET_ZERO;
      axes.first_z  <= AXIS_RESET_ZERO;
      axes.second_x <= AXIS_RESET_ZERO;
      axes.second_y <= AXIS_RESET_ONE;
      axes.second_z <= AXIS_RESET_ZERO;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FIRST_X:  axes.first_x  <= cfg_data;
        CFG_FIRST_Y:  axes.first_y  <= cfg_data;
        CFG_FIRST_Z:  axes.first_z  <= cfg_data;
        CFG_SECOND_X: axes.second_x <= cfg_data;
        CFG_SECOND_Y: axes.second_y <= cfg_data;
        CFG_SECOND_Z: axes.second_z <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  apec_front #(
    .COORD_WIDTH   (COORD_WIDTH),
    .AXIS_FRAC_BITS(AXIS_FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .point_valid(point_valid),
    .point_ready(point_ready),
    .point      (point),
    .axes       (axes),
    .queue_count(queue_count),
    .push       (push),
    .push_data  (push_data)
  );

  apec_queue #(
    .WIDTH(ENTRY_W)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .pop      (pop),
    .pop_data (pop_data),
    .count    (queue_count)
  );

  apec_back #(
    .COORD_WIDTH   (COORD_WIDTH),
    .AXIS_FRAC_BITS(AXIS_FRAC_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .axes        (axes),
    .queue_count (queue_count),
    .pop_data    (pop_data),
    .pop         (pop),
    .center_valid(center_valid),
    .center_ready(center_ready),
    .center      (center)
  );

endmodule
